// ===== rtl/slot_allocator_reuse_delay_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Slot allocator assertion macros
// Shared property shorthands for the slot allocator checkers.
// ---------------------------------------------------------------------------
`ifndef SLOT_ALLOCATOR_REUSE_DELAY_UNIT_ASSERT_SVH
`define SLOT_ALLOCATOR_REUSE_DELAY_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot allocator: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot allocator: next-cycle check failed");

`endif

// ===== rtl/sra_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Slot allocator package
// Types, request and status codes, and register indexes.
// ---------------------------------------------------------------------------
package sra_pkg;

    localparam int SRA_SLOTS = 2048;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int SLOT_IDX_W = 11;
    localparam int STATUS_W   = 3;

    // Request codes
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FORCE = 2'd1;
    localparam logic [1:0] REQ_FREE  = 2'd2;
    localparam logic [1:0] REQ_REUSE = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY         = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_FREE      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_PROTECTED    = 3'd5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CLIENTS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REUSE_DELAY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EARLY_WINDOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXPLICIT_DEL   = 3'd4;

    typedef struct packed {
        logic [7:0]  max_clients;
        logic [11:0] capacity_limit;
        logic [15:0] reuse_delay_ms;
        logic [15:0] early_window_ms;
        logic        explicit_delete_enable;
    } cfg_t;

    typedef struct packed {
        logic        free_flag;
        logic [31:0] free_time;
    } slot_entry_t;

endpackage

// ===== rtl/slot_allocator_reuse_delay_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Slot allocator with reuse delay
// Allocates, force-allocates, frees and releases slots held in one table.
// ---------------------------------------------------------------------------
// One request is taken at a time and gives exactly one result. Forced
// allocations and frees look up the one indexed slot; an index at or
// above the high-water mark fails without a lookup. Allocation and
// immediate-reuse requests walk the slot table through its single read port,
// one slot per cycle from max_clients+1 up to the slot below the high-water
// mark. An allocation stops at the first qualifying slot. The longest walk
// covers slots 1 to SLOTS-1. A finished result waits in an output register
// while the next request is taken; a stalled result holds the request
// behind it in its done state until the output register is free. The table
// needs no clearing pass after reset: slots at and above the high-water
// mark are written as they are grown.
module slot_allocator_reuse_delay_unit
    import sra_pkg::*;
#(
    parameter int SLOTS = SRA_SLOTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            req_type,
    input  logic [SLOT_IDX_W-1:0] slot_index,
    input  logic [31:0]           now_time,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [SLOT_IDX_W-1:0] granted_slot,
    output logic                  explicit_delete
);

    localparam int AW = $clog2(SLOTS);

    cfg_t        cfg_reg;
    logic        rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    slot_entry_t rd_data, wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_clients            <= 8'd1;
            cfg_reg.capacity_limit         <= 12'd2048;
            cfg_reg.reuse_delay_ms         <= 16'd1000;
            cfg_reg.early_window_ms        <= 16'd2000;
            cfg_reg.explicit_delete_enable <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MAX_CLIENTS:    cfg_reg.max_clients            <= cfg_data[7:0];
                REG_CAPACITY_LIMIT: cfg_reg.capacity_limit         <= cfg_data[11:0];
                REG_REUSE_DELAY:    cfg_reg.reuse_delay_ms         <= cfg_data;
                REG_EARLY_WINDOW:   cfg_reg.early_window_ms        <= cfg_data;
                REG_EXPLICIT_DEL:   cfg_reg.explicit_delete_enable <= cfg_data[0];
                default:            cfg_reg                        <= cfg_reg;
            endcase
        end
    end

    sra_scan_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .slot_index      (slot_index),
        .now_time        (now_time),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .granted_slot    (granted_slot),
        .explicit_delete (explicit_delete),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data)
    );

    sra_slot_ram #(
        .SLOTS (SLOTS)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

// ===== rtl/sra_slot_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Slot table memory
// One write port and one read port; read data registered.
// ---------------------------------------------------------------------------
module sra_slot_ram
    import sra_pkg::*;
#(
    parameter int SLOTS = SRA_SLOTS
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(SLOTS)-1:0] rd_addr,
    output slot_entry_t              rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(SLOTS)-1:0] wr_addr,
    input  slot_entry_t              wr_data
);

    slot_entry_t mem [SLOTS];
    slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sra_scan_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Slot allocator sequencer
// Runs each request against the slot table: single lookups, linear scans,
// high-water growth, and holds the result in an output register.
// ---------------------------------------------------------------------------
module sra_scan_ctrl
    import sra_pkg::*;
#(
    parameter int SLOTS = SRA_SLOTS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               req_type,
    input  logic [SLOT_IDX_W-1:0]    slot_index,
    input  logic [31:0]              now_time,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [SLOT_IDX_W-1:0]    granted_slot,
    output logic                     explicit_delete,
    output logic                     rd_en,
    output logic [$clog2(SLOTS)-1:0] rd_addr,
    input  slot_entry_t              rd_data,
    output logic                     wr_en,
    output logic [$clog2(SLOTS)-1:0] wr_addr,
    output slot_entry_t              wr_data
);

    localparam int AW    = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (CNT_W > 12) ? CNT_W : 12;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_LOOK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      hw_reg, hw_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic                  out_valid_reg, out_valid_next;

    logic [1:0]            req_reg, req_next;
    logic [SLOT_IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]           now_reg, now_next;
    logic [CMP_W-1:0]      ptr_reg, ptr_next;
    logic [AW-1:0]         chk_reg, chk_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [SLOT_IDX_W-1:0] res_slot_reg, res_slot_next;
    logic                  res_del_reg, res_del_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [SLOT_IDX_W-1:0] out_slot_reg, out_slot_next;
    logic                  out_del_reg, out_del_next;

    logic [CMP_W-1:0]      hw_ext, first_ext, cap_ext, slots_ext, in_idx_ext, idx_ext;
    logic [CMP_W-1:0]      maxc_ext;
    logic                  can_grow, scan_more, slot_ok, hit;
    logic [31:0]           age;

    assign hw_ext     = CMP_W'(hw_reg);
    assign maxc_ext   = CMP_W'(cfg.max_clients);
    assign first_ext  = maxc_ext + CMP_W'(1);
    assign cap_ext    = CMP_W'(cfg.capacity_limit);
    assign slots_ext  = CMP_W'(SLOTS);
    assign in_idx_ext = CMP_W'(slot_index);
    assign idx_ext    = CMP_W'(idx_reg);
    assign can_grow   = (hw_ext < cap_ext) && (hw_ext < slots_ext);
    assign scan_more  = ptr_reg < hw_ext;

    // A slot qualifies by an early free time or by its age.
    assign age     = now_reg - rd_data.free_time;
    assign slot_ok = (rd_data.free_time < {16'd0, cfg.early_window_ms})
                  || ((now_reg >= rd_data.free_time)
                      && (age >= {16'd0, cfg.reuse_delay_ms}));
    assign hit     = chk_vld_reg && rd_data.free_flag
                  && ((req_reg == REQ_REUSE) || slot_ok);

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        hw_next         = hw_reg;
        chk_vld_next    = chk_vld_reg;
        out_valid_next  = out_valid_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        now_next        = now_reg;
        ptr_next        = ptr_reg;
        chk_next        = chk_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_del_next    = res_del_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_del_next    = out_del_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next        = req_type;
                    idx_next        = slot_index;
                    now_next        = now_time;
                    res_status_next = ST_OK;
                    res_slot_next   = '0;
                    res_del_next    = 1'b0;
                    if ((req_type == REQ_ALLOC) || (req_type == REQ_REUSE))
                    begin
                        ptr_next     = first_ext;
                        chk_vld_next = 1'b0;
                        state_next   = S_SCAN;
                    end
                    else if (in_idx_ext >= hw_ext)
                    begin
                        res_status_next = ST_BAD_INDEX;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(slot_index);
                        state_next = S_LOOK;
                    end
                end
            end

            S_SCAN:
            begin
                if ((req_reg == REQ_ALLOC) && hit)
                begin
                    // Take the first qualifying slot; drop reads in flight.
                    wr_en           = 1'b1;
                    wr_addr         = chk_reg;
                    wr_data         = '{free_flag: 1'b0, free_time: rd_data.free_time};
                    res_slot_next   = SLOT_IDX_W'(chk_reg);
                    res_del_next    = (rd_data.free_time == 32'd0)
                                   && cfg.explicit_delete_enable;
                    chk_vld_next    = 1'b0;
                    state_next      = S_DONE;
                end
                else
                begin
                    if (hit)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = chk_reg;
                        wr_data = '{free_flag: 1'b1, free_time: 32'd0};
                    end
                    if (scan_more)
                    begin
                        rd_en        = 1'b1;
                        rd_addr      = AW'(ptr_reg);
                        chk_next     = AW'(ptr_reg);
                        chk_vld_next = 1'b1;
                        ptr_next     = ptr_reg + CMP_W'(1);
                    end
                    else
                    begin
                        chk_vld_next = 1'b0;
                    end
                    if (!scan_more && !chk_vld_reg)
                    begin
                        if (req_reg == REQ_ALLOC)
                        begin
                            if (can_grow)
                            begin
                                wr_en         = 1'b1;
                                wr_addr       = AW'(hw_reg);
                                wr_data       = '{free_flag: 1'b0, free_time: 32'd0};
                                res_slot_next = SLOT_IDX_W'(hw_reg);
                                hw_next       = hw_reg + CNT_W'(1);
                            end
                            else
                            begin
                                res_status_next = ST_NO_FREE;
                            end
                        end
                        state_next = S_DONE;
                    end
                end
            end

            S_LOOK:
            begin
                if (req_reg == REQ_FORCE)
                begin
                    if (!rd_data.free_flag)
                    begin
                        res_status_next = ST_BUSY;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = AW'(idx_reg);
                        wr_data       = '{free_flag: 1'b0, free_time: rd_data.free_time};
                        res_slot_next = idx_reg;
                    end
                end
                else
                begin
                    priority if (rd_data.free_flag)
                    begin
                        res_status_next = ST_ALREADY_FREE;
                    end
                    else if ((idx_reg != '0) && (idx_ext <= maxc_ext))
                    begin
                        res_status_next = ST_PROTECTED;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(idx_reg);
                        wr_data = '{free_flag: 1'b1, free_time: now_reg};
                    end
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_del_next    = res_del_reg;
                    state_next      = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hw_reg        <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hw_reg        <= hw_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        idx_reg        <= idx_next;
        now_reg        <= now_next;
        ptr_reg        <= ptr_next;
        chk_reg        <= chk_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_del_reg    <= res_del_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_del_reg    <= out_del_next;
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign granted_slot    = out_slot_reg;
    assign explicit_delete = out_del_reg;

endmodule

// ===== rtl/sra_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Slot allocator port checker
// Watches the top-level ports for result and request-flow consistency.
// ---------------------------------------------------------------------------
`include "slot_allocator_reuse_delay_unit_assert.svh"

module sra_checker
    import sra_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [STATUS_W-1:0]   status,
    input logic [SLOT_IDX_W-1:0] granted_slot,
    input logic                  explicit_delete
);

    // The unit is not ready in the cycle after it accepts a request.
    `SRA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

    // A failed request grants nothing.
    `SRA_ASSERT_SAME(a_fail_no_grant, clk, rst_n, out_valid && (status != ST_OK), (granted_slot == '0) && !explicit_delete)

    // Only a successful allocation may flag an explicit delete.
    `SRA_ASSERT_SAME(a_del_needs_ok, clk, rst_n, out_valid && explicit_delete, status == ST_OK)

    // A stalled result holds.
    `SRA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(granted_slot))

endmodule

bind slot_allocator_reuse_delay_unit sra_checker u_sra_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .granted_slot    (granted_slot),
    .explicit_delete (explicit_delete)
);
